// File: hdl/s8wp_pkg.sv
// Package for the Simple-8b word packer: field widths, store geometry and
// the selector tables. No dependencies; compile first.
package s8wp_pkg;

	localparam int VALUE_W     = 64;
	localparam int DATA_BITS   = 60;
	localparam int SEL_BITS    = 4;
	localparam int SEL_MIN     = 1;
	localparam int SEL_MAX     = 14;
	localparam int STORE_DEPTH = 60;
	localparam int WORD_W      = DATA_BITS + SEL_BITS;

	localparam int WIDTH_W = $clog2(DATA_BITS + 1);
	localparam int COUNT_W = $clog2(STORE_DEPTH + 1);
	localparam int PTR_W   = $clog2(STORE_DEPTH);
	localparam int NSEL_W  = 7;

	localparam logic [VALUE_W-1:0] SEL_MASK = 64'h0000_0000_0000_000F;

	typedef logic [SEL_BITS-1:0] sel_t;
	typedef logic [WIDTH_W-1:0]  width_t;

	typedef struct packed {
		width_t                 width;
		logic [DATA_BITS-1:0]   data;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// bits per value for each selector
	function automatic width_t sel_bits(input sel_t sel);
		width_t b;
		case (sel)
			4'd0:    b = 6'd0;
			4'd1:    b = 6'd1;
			4'd2:    b = 6'd2;
			4'd3:    b = 6'd3;
			4'd4:    b = 6'd4;
			4'd5:    b = 6'd5;
			4'd6:    b = 6'd6;
			4'd7:    b = 6'd7;
			4'd8:    b = 6'd8;
			4'd9:    b = 6'd10;
			4'd10:   b = 6'd12;
			4'd11:   b = 6'd15;
			4'd12:   b = 6'd20;
			4'd13:   b = 6'd30;
			4'd14:   b = 6'd60;
			default: b = 6'd0;
		endcase
		return b;
	endfunction

	// values per word for each selector
	function automatic logic [NSEL_W-1:0] sel_count(input sel_t sel);
		logic [NSEL_W-1:0] n;
		case (sel)
			4'd0:    n = 7'd120;
			4'd1:    n = 7'd60;
			4'd2:    n = 7'd30;
			4'd3:    n = 7'd20;
			4'd4:    n = 7'd15;
			4'd5:    n = 7'd12;
			4'd6:    n = 7'd10;
			4'd7:    n = 7'd8;
			4'd8:    n = 7'd7;
			4'd9:    n = 7'd6;
			4'd10:   n = 7'd5;
			4'd11:   n = 7'd4;
			4'd12:   n = 7'd3;
			4'd13:   n = 7'd2;
			4'd14:   n = 7'd1;
			default: n = 7'd1;
		endcase
		return n;
	endfunction

endpackage

// File: hdl/s8wp_if.sv
// Handshake channels of the Simple-8b word packer: value items in,
// result items out. Depends on s8wp_pkg.
interface s8wp_in_if;
	import s8wp_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface s8wp_out_if;
	import s8wp_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] packed_word;
	logic              word_valid;
	logic              accepted;
	logic              last;
	modport source (output valid, output packed_word, output word_valid,
		output accepted, output last, input ready);
	modport sink   (input valid, input packed_word, input word_valid,
		input accepted, input last, output ready);
endinterface

// File: hdl/s8wp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module s8wp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: hdl/simple8b_word_packer_top.sv
// Simple-8b word packer, top level. A value that fits passes the width search (one
// 15-bit chunk per step from the top), the fit check and the status state; a too-wide
// value goes straight to status. No new value is taken until the last one's status item
// is loaded, which waits on result stalls. Each word due first adds a selector scan, a
// pack pass, an emit step and, if values remain, a rescan of them, all through the single
// RAM read port of the pending store. Reset clears control, count, head and max width.
module simple8b_word_packer_top (
	input  logic       clk,
	input  logic       arst_n,
	s8wp_in_if.sink    values,
	s8wp_out_if.source results
);
	import s8wp_pkg::*;

	localparam int CHUNK_W    = 15;
	localparam int NUM_CHUNKS = DATA_BITS / CHUNK_W;
	localparam int CHK_W      = $clog2(NUM_CHUNKS);
	localparam int PROD_W     = WIDTH_W + COUNT_W + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WID  = 3'd1;
	localparam logic [2:0] ST_FIT  = 3'd2;
	localparam logic [2:0] ST_SEL  = 3'd3;
	localparam logic [2:0] ST_PACK = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;
	localparam logic [2:0] ST_MAXW = 3'd6;
	localparam logic [2:0] ST_STAT = 3'd7;

	// Circular-buffer address: head plus offset, wrapped at the store depth.
	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
		input logic [PTR_W-1:0] b);
		logic [PTR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (PTR_W+1)'(STORE_DEPTH)) begin
			s = s - (PTR_W+1)'(STORE_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	// Highest set bit of one chunk of the value.
	function automatic logic [3:0] msb_pos(input logic [CHUNK_W-1:0] c);
		logic [3:0] p;
		p = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			if (c[i]) begin
				p = 4'(i);
			end
		end
		return p;
	endfunction

	// Selector whose value count equals n, or zero if n is no word boundary.
	function automatic sel_t ckpt_sel(input logic [COUNT_W-1:0] n);
		sel_t s;
		s = '0;
		for (int k = SEL_MIN; k <= SEL_MAX; k++) begin
			if (sel_count(sel_t'(k)) == NSEL_W'(n)) begin
				s = sel_t'(k);
			end
		end
		return s;
	endfunction

	// Shift the pack accumulator up by one slot of the chosen selector.
	function automatic logic [DATA_BITS-1:0] shl_sel(input logic [DATA_BITS-1:0] a,
		input sel_t sel);
		logic [DATA_BITS-1:0] r;
		r = a;
		for (int k = SEL_MIN; k <= SEL_MAX; k++) begin
			if (sel == sel_t'(k)) begin
				r = a << sel_bits(sel_t'(k));
			end
		end
		return r;
	endfunction

	// Sequencer and input item
	logic [2:0]           state_q;
	logic [DATA_BITS-1:0] v_q;
	width_t               w_q;
	logic                 acc_ok_q;
	logic [CHK_W-1:0]     chk_q;

	// Pending store bookkeeping
	logic [PTR_W-1:0]     head_q;
	logic [COUNT_W-1:0]   count_q;
	width_t               maxw_q;

	// Scan unit: read issue and one stage of returned data
	logic [PTR_W-1:0]     idx_q;
	logic                 iss_q;
	logic                 rvld_s1;
	logic [PTR_W-1:0]     ridx_s1;
	width_t               runmax_q;
	sel_t                 sel_q;
	logic [DATA_BITS-1:0] acc_q;

	// Output register
	logic                 out_valid_q;
	logic [WORD_W-1:0]    out_word_q;
	logic                 out_wv_q;
	logic                 out_acc_q;
	logic                 out_last_q;

	// RAM ports
	entry_t               rd_entry;
	entry_t               wr_entry;
	logic                 ram_we;
	logic [PTR_W-1:0]     ram_waddr;
	logic [PTR_W-1:0]     ram_raddr;

	// Datapath
	logic [CHUNK_W-1:0]   chunk;
	width_t               chunk_base;
	width_t               w_found;
	width_t               fit_m;
	logic [PROD_W-1:0]    fit_prod;
	logic                 fits;
	width_t               scan_m;
	logic [COUNT_W-1:0]   scan_n;
	sel_t                 scan_cs;
	logic                 scan_fail;
	logic                 scan_take;
	logic                 scan_last;
	sel_t                 next_sel;
	logic [NSEL_W-1:0]    next_n;
	logic [NSEL_W-1:0]    cur_n;
	logic [COUNT_W-1:0]   cur_n_c;
	logic                 issue_last_up;
	logic                 out_free;

	// Width search: one 15-bit chunk per cycle from the top.
	assign chunk      = v_q[chk_q*CHUNK_W +: CHUNK_W];
	assign chunk_base = WIDTH_W'(chk_q) * WIDTH_W'(CHUNK_W);
	assign w_found    = chunk_base + WIDTH_W'(msb_pos(chunk)) + WIDTH_W'(1);

	// Fit check: widest width times the count with the new value, against 60 bits.
	assign fit_m    = (maxw_q > w_q) ? maxw_q : w_q;
	assign fit_prod = PROD_W'(fit_m) * (PROD_W'(count_q) + PROD_W'(1));
	assign fits     = fit_prod <= PROD_W'(DATA_BITS);

	// Scan step on the entry returned by the RAM this cycle.
	assign scan_m    = (rd_entry.width > runmax_q) ? rd_entry.width : runmax_q;
	assign scan_n    = COUNT_W'(ridx_s1) + COUNT_W'(1);
	assign scan_cs   = ckpt_sel(scan_n);
	assign scan_fail = (scan_cs != '0) && (scan_m > sel_bits(scan_cs));
	assign scan_take = (scan_cs != '0) && !scan_fail;
	assign scan_last = scan_n == count_q;
	assign next_sel  = scan_take ? scan_cs : sel_q;
	assign next_n    = sel_count(next_sel);
	assign cur_n     = sel_count(sel_q);
	assign cur_n_c   = cur_n[COUNT_W-1:0];

	assign issue_last_up = (COUNT_W'(idx_q) + COUNT_W'(1)) == count_q;
	assign out_free      = !out_valid_q || results.ready;

	assign ram_raddr = wrap_add(head_q, idx_q);
	assign ram_we    = (state_q == ST_FIT) && fits;
	assign ram_waddr = wrap_add(head_q, PTR_W'(count_q));
	assign wr_entry  = '{width: w_q, data: v_q};

	s8wp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (iss_q),
		.raddr (ram_raddr),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			v_q         <= '0;
			w_q         <= '0;
			acc_ok_q    <= 1'b0;
			chk_q       <= '0;
			head_q      <= '0;
			count_q     <= '0;
			maxw_q      <= '0;
			idx_q       <= '0;
			iss_q       <= 1'b0;
			rvld_s1     <= 1'b0;
			ridx_s1     <= '0;
			runmax_q    <= '0;
			sel_q       <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			out_wv_q    <= 1'b0;
			out_acc_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			// Drop the result item once taken; a load below overrides.
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			// Track the read in flight; the RAM returns it next cycle.
			rvld_s1 <= iss_q;
			ridx_s1 <= idx_q;

			case (state_q)
				ST_IDLE: begin
					if (values.valid) begin
						v_q <= values.value[DATA_BITS-1:0];
						if (|values.value[VALUE_W-1:DATA_BITS]) begin
							acc_ok_q <= 1'b0;
							state_q  <= ST_STAT;
						end else begin
							chk_q   <= CHK_W'(NUM_CHUNKS - 1);
							state_q <= ST_WID;
						end
					end
				end
				ST_WID: begin
					// Zero counts as one bit wide.
					if (chunk != '0) begin
						w_q     <= w_found;
						state_q <= ST_FIT;
					end else if (chk_q == '0) begin
						w_q     <= WIDTH_W'(1);
						state_q <= ST_FIT;
					end else begin
						chk_q <= chk_q - CHK_W'(1);
					end
				end
				ST_FIT: begin
					if (fits) begin
						count_q  <= count_q + COUNT_W'(1);
						maxw_q   <= fit_m;
						acc_ok_q <= 1'b1;
						state_q  <= ST_STAT;
					end else begin
						// Start the selector scan over the oldest values.
						idx_q    <= '0;
						iss_q    <= 1'b1;
						runmax_q <= '0;
						sel_q    <= sel_t'(SEL_MAX);
						state_q  <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (iss_q) begin
						idx_q <= idx_q + PTR_W'(1);
						if (issue_last_up) begin
							iss_q <= 1'b0;
						end
					end
					if (rvld_s1) begin
						runmax_q <= scan_m;
						if (scan_take) begin
							sel_q <= scan_cs;
						end
						// A failed boundary fails every longer prefix: stop there.
						if (scan_fail || scan_last) begin
							sel_q   <= next_sel;
							idx_q   <= PTR_W'(next_n - NSEL_W'(1));
							iss_q   <= 1'b1;
							rvld_s1 <= 1'b0;
							acc_q   <= '0;
							state_q <= ST_PACK;
						end
					end
				end
				ST_PACK: begin
					// Read the chosen values newest first and shift them in.
					if (iss_q) begin
						if (idx_q == '0) begin
							iss_q <= 1'b0;
						end else begin
							idx_q <= idx_q - PTR_W'(1);
						end
					end
					if (rvld_s1) begin
						acc_q <= shl_sel(acc_q, sel_q) | rd_entry.data;
						if (ridx_s1 == '0) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_word_q  <= {acc_q, sel_q};
						out_wv_q    <= 1'b1;
						out_acc_q   <= 1'b0;
						out_last_q  <= 1'b0;
						head_q      <= wrap_add(head_q, PTR_W'(cur_n_c));
						count_q     <= count_q - cur_n_c;
						idx_q       <= '0;
						runmax_q    <= '0;
						if (count_q == cur_n_c) begin
							maxw_q  <= '0;
							state_q <= ST_FIT;
						end else begin
							iss_q   <= 1'b1;
							state_q <= ST_MAXW;
						end
					end
				end
				ST_MAXW: begin
					// Rescan the remaining values for the new max width.
					if (iss_q) begin
						idx_q <= idx_q + PTR_W'(1);
						if (issue_last_up) begin
							iss_q <= 1'b0;
						end
					end
					if (rvld_s1) begin
						runmax_q <= scan_m;
						if (scan_last) begin
							maxw_q  <= scan_m;
							state_q <= ST_FIT;
						end
					end
				end
				ST_STAT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_word_q  <= '0;
						out_wv_q    <= 1'b0;
						out_acc_q   <= acc_ok_q;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign values.ready        = state_q == ST_IDLE;
	assign results.valid       = out_valid_q;
	assign results.packed_word = out_word_q;
	assign results.word_valid  = out_wv_q;
	assign results.accepted    = out_acc_q;
	assign results.last        = out_last_q;

`ifndef ASSERT_OFF
	// Between items the pending values always fit one word.
	a_idle_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (PROD_W'(maxw_q) * PROD_W'(count_q)) <= PROD_W'(DATA_BITS))
		else $error("pending values exceed one word while idle");

	// An emitted word carries a real selector and is never the final item.
	a_word_sel: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.word_valid |->
			(results.packed_word & SEL_MASK) != '0 && !results.last)
		else $error("word item with selector zero or marked last");

	// An accepted status leaves at least the new value pending.
	a_acc_count: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.last && results.accepted |-> count_q != '0 && maxw_q != '0)
		else $error("accepted status with empty pending store");

	// The pending count never passes the store depth.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(STORE_DEPTH))
		else $error("pending count overflow");
`endif

endmodule

// File: tb/tb.sv
// Self-checking bench for simple8b_word_packer_top: random and directed value items,
// a bit-accurate Simple-8b packing predictor and an in-order result check.
// Depends on s8wp_pkg, s8wp_in_if / s8wp_out_if and the top level RTL.

typedef struct packed {
	logic [63:0] packed_word;
	logic        word_valid;
	logic        accepted;
	logic        last;
} word_result_t;

class packed_word_checker;
	int unsigned  lane_bits [16] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 10, 12, 15, 20, 30, 60, 0};
	int unsigned  lane_count[16] = '{120, 60, 30, 20, 15, 12, 10, 8, 7, 6, 5, 4, 3, 2, 1, 1};
	logic [59:0]  pending_vals[$];
	int unsigned  widest_pending;
	word_result_t due_results[$];
	int           errors;

	function new();
		widest_pending = 0;
		errors = 0;
	endfunction

	task report(string msg);
		errors++;
		$display("MISMATCH: %s", msg);
	endtask

	// append one predicted result at the tail of the queue
	function void queue_result(logic [63:0] word, logic wv, logic acc, logic lst);
		word_result_t r;
		r.packed_word = word;
		r.word_valid  = wv;
		r.accepted    = acc;
		r.last        = lst;
		due_results.insert(due_results.size(), r);
	endfunction

	// zero still takes one bit
	function int unsigned bit_width(logic [59:0] v);
		for (int i = 59; i >= 0; i--)
			if (v[i])
				return i + 1;
		return 1;
	endfunction

	function bit fits_with(int unsigned w);
		int unsigned m;
		m = (widest_pending > w) ? widest_pending : w;
		return m * (pending_vals.size() + 1) <= s8wp_pkg::DATA_BITS;
	endfunction

	// pick the first selector whose prefix fits, pack it, drop it from the store
	function logic [63:0] pack_word();
		int unsigned sel, n, b, widest, w;
		logic [63:0] word;
		sel = s8wp_pkg::SEL_MAX;
		for (int s = s8wp_pkg::SEL_MIN; s <= s8wp_pkg::SEL_MAX; s++) begin
			n = lane_count[s];
			if (pending_vals.size() < n)
				continue;
			widest = 0;
			for (int i = 0; i < n; i++) begin
				w = bit_width(pending_vals[i]);
				if (w > widest)
					widest = w;
			end
			if (widest <= lane_bits[s]) begin
				sel = s;
				break;
			end
		end
		n = lane_count[sel];
		b = lane_bits[sel];
		word = 64'(sel);
		for (int i = 0; i < n && i < pending_vals.size(); i++)
			word |= 64'(pending_vals[i]) << (b * i + s8wp_pkg::SEL_BITS);
		if (n > pending_vals.size())
			n = pending_vals.size();
		repeat (n) void'(pending_vals.pop_front());
		return word;
	endfunction

	function void note_value(logic [63:0] v);
		int unsigned w;
		if (v[63:s8wp_pkg::DATA_BITS] != '0) begin
			queue_result(64'd0, 1'b0, 1'b0, 1'b1);
			return;
		end
		w = bit_width(v[59:0]);
		while (pending_vals.size() > 0 && !fits_with(w)) begin
			queue_result(pack_word(), 1'b1, 1'b0, 1'b0);
			widest_pending = 0;
			foreach (pending_vals[i])
				if (bit_width(pending_vals[i]) > widest_pending)
					widest_pending = bit_width(pending_vals[i]);
		end
		if (w > widest_pending)
			widest_pending = w;
		if (pending_vals.size() < s8wp_pkg::STORE_DEPTH)
			pending_vals.insert(pending_vals.size(), v[59:0]);
		queue_result(64'd0, 1'b0, 1'b1, 1'b1);
	endfunction

	task check_result(word_result_t got);
		word_result_t want;
		if (due_results.size() == 0) begin
			report($sformatf("unexpected result word=%h wv=%b acc=%b last=%b",
				got.packed_word, got.word_valid, got.accepted, got.last));
			return;
		end
		want = due_results.pop_front();
		if (got.packed_word !== want.packed_word)
			report($sformatf("packed_word %h, want %h", got.packed_word, want.packed_word));
		if (got.word_valid !== want.word_valid)
			report($sformatf("word_valid %b, want %b", got.word_valid, want.word_valid));
		if (got.accepted !== want.accepted)
			report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
		if (got.last !== want.last)
			report($sformatf("last %b, want %b", got.last, want.last));
	endtask
endclass

module tb;
	import s8wp_pkg::*;

	// the slowest legal run stays far below this; anything past it is a hang
	localparam int CYCLE_LIMIT  = 20_000_000;
	// together with the directed items, about 200 values in all
	localparam int RANDOM_ITEMS = 181;
	// enough idle cycles to catch a stray result after the last status item
	localparam int DRAIN_CYCLES = 64;

	logic clk;
	logic arst_n;

	s8wp_in_if  values_if ();
	s8wp_out_if results_if ();

	simple8b_word_packer_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.values  (values_if),
		.results (results_if)
	);

	packed_word_checker pack_check = new();

	// sender burst state: items left in the current burst
	int unsigned burst_left = 1;

	// widths that exactly match a selector lane, so runs tend to fill whole words
	int unsigned lane_widths [14] = '{1, 2, 3, 4, 5, 6, 7, 8, 10, 12, 15, 20, 30, 60};

	// directed items: empty store, rejects just above and far above 60 bits,
	// the widest legal value, a reject while values are pending, wide values
	// that flush several small ones, and alternating bit patterns
	logic [63:0] directed_vals [19] = '{
		64'h0000_0000_0000_0000,
		64'hFFFF_FFFF_FFFF_FFFF,
		64'h1000_0000_0000_0000,
		64'h0FFF_FFFF_FFFF_FFFF,
		64'h0000_0000_0000_0001,
		64'h0000_0000_0000_0001,
		64'h0000_0000_0000_0002,
		64'h0000_0000_0000_0003,
		64'h0000_0000_0000_0007,
		64'h0000_0000_0000_0000,
		64'h8000_0000_0000_0001,
		64'h0000_0000_000F_FFFF,
		64'h0800_0000_0000_0000,
		64'h0000_0000_3FFF_FFFF,
		64'h0000_0000_2000_0000,
		64'h0000_0000_0000_0FFF,
		64'h0AAA_AAAA_AAAA_AAAA,
		64'h0555_5555_5555_5555,
		64'h0000_0000_0000_0001
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hold reset from time zero, release it once on a rising edge
	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// random value of exactly or at most w bits (1 <= w <= 60)
	function automatic logic [63:0] rand_of_width(int unsigned w);
		logic [63:0] v;
		v = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
		if ($urandom_range(0, 1) == 1)
			v[w-1] = 1'b1;
		return v;
	endfunction

	// present one item, hold it until the handshake, then note it for prediction;
	// at the end of a burst drop valid for a random gap (or skip the gap entirely)
	task automatic send_item(input logic [63:0] v);
		int unsigned gap;
		values_if.valid <= 1'b1;
		values_if.value <= v;
		do @(posedge clk); while (values_if.ready !== 1'b1);
		pack_check.note_value(v);
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				values_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// result side: check every accepted item, then advance the stall pattern;
	// each time the phase wraps the 32-bit pattern, reload it as always-ready, random, mostly ready or sparse
	initial begin : receiver
		logic [31:0] stall_pat;
		int          phase;
		results_if.ready = 1'b0;
		stall_pat = '1;
		phase = 0;
		forever begin
			@(posedge clk);
			if (arst_n && results_if.valid === 1'b1 && results_if.ready === 1'b1)
				pack_check.check_result('{results_if.packed_word, results_if.word_valid,
					results_if.accepted, results_if.last});
			if (phase == 0) begin
				case ($urandom_range(0, 3))
					0:       stall_pat = '1;
					1:       stall_pat = $urandom;
					2:       stall_pat = $urandom | $urandom;
					default: stall_pat = $urandom & $urandom;
				endcase
			end
			results_if.ready <= stall_pat[phase];
			phase = (phase + 1) % 32;
		end
	end

	// end the run if the block hangs
	initial begin : watchdog
		int cycle_count;
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("simple8b_word_packer_top regression: fail");
		$finish;
	end

	initial begin : stimulus
		logic [63:0] v;
		int unsigned w;
		int unsigned run_len;
		int unsigned sent;
		values_if.valid = 1'b0;
		values_if.value = '0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (directed_vals[i])
			send_item(directed_vals[i]);

		// runs of values sharing a width class fill words of one selector;
		// zeros, off-width noise and too-wide rejects break the runs up
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 6) begin
				v = {$urandom, $urandom};
				v[63:DATA_BITS] = 4'($urandom_range(1, 15));
				send_item(v);
				sent++;
			end else begin
				if ($urandom_range(0, 4) == 0)
					w = $urandom_range(1, DATA_BITS);
				else
					w = lane_widths[$urandom_range(0, 13)];
				run_len = $urandom_range(1, DATA_BITS / w + 3);
				// trim the last run so the total lands on the item budget
				if (run_len > RANDOM_ITEMS - sent)
					run_len = RANDOM_ITEMS - sent;
				repeat (run_len) begin
					case ($urandom_range(0, 9))
						0:       v = '0;
						1:       v = rand_of_width($urandom_range(1, DATA_BITS));
						default: v = rand_of_width(w);
					endcase
					send_item(v);
					sent++;
				end
			end
		end
		values_if.valid <= 1'b0;

		// drain: wait for every predicted result, then watch for strays
		while (pack_check.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pack_check.errors == 0)
			$display("simple8b_word_packer_top regression: pass");
		else
			$display("simple8b_word_packer_top regression: fail");
		$finish;
	end

endmodule

// File: sim.f
hdl/s8wp_pkg.sv
hdl/s8wp_if.sv
hdl/s8wp_ram.sv
hdl/simple8b_word_packer_top.sv
tb/tb.sv
